// ----- hdl/sprite_sort_and_batch_macros.svh -----
// Assertion macros shared by the sprite sort and batch block.
`ifndef SPRITE_SORT_AND_BATCH_MACROS_SVH
`define SPRITE_SORT_AND_BATCH_MACROS_SVH

// Check that a condition implies a consequence at the same edge.
`define SSB_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence at the next edge.
`define SSB_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ssb_pkg.sv -----
// Package with types and constants of the sprite sort and batch block.
`timescale 1ns / 1ps
`default_nettype none
package ssb_pkg;
    localparam int MaxSprites     = 32;
    localparam int VertsPerSprite = 6;
    localparam int IdxW           = $clog2(MaxSprites);
    localparam int CntW           = $clog2(MaxSprites + 1);

    typedef enum logic [1:0] {
        MODE_TEXTURE  = 2'd0,
        MODE_DEPTH_UP = 2'd1,
        MODE_DEPTH_DN = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_DONE,
        ST_RUN_RD,
        ST_RUN_LD,
        ST_RUN_CMP,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT
    } t_state;

    // Compare result of the shared unit.
    typedef struct packed {
        logic ahead;
        logic same_tex;
    } t_cmp;
endpackage
`default_nettype wire

// ----- hdl/sprite_sort_and_batch.sv -----
// Sprite sort and batch block: collect a frame, insertion-sort it, emit batches.
// Usage:
//   s_axis carries one sprite item per transaction: tdata = {depth_key,
//   texture_id, carries_sprite}, tlast = frame_end. Items load one per cycle.
//   On tlast the block stops taking input and runs an insertion sort with one
//   shared compare unit. Batching then finds the runs of equal texture in the
//   sorted order and emits the results. m_axis carries one result per sorted
//   sprite; tlast marks the final one. A stalled receiver holds the result and
//   the sequencer waits before placing the next one. Sprites past 32 per frame
//   are dropped and flagged in the results. i_cfg_we writes sort_mode; the
//   user must assert it only while idle, as the block does not enforce this.
//   Reset (i_rst_n low, synchronous) empties the frame, clears overflow and
//   sets sort_mode to texture order.
`timescale 1ns / 1ps
`default_nettype none
module sprite_sort_and_batch (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // carries_sprite[0], texture_id[32:1], depth_key[64:33], zero pad
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sprite_index[4:0], sprite_texture[36:5], batch_first[37],
    // batch_offset[45:38], batch_vertices[53:46], overflowed[54], zero pad
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    import ssb_pkg::*;
`include "sprite_sort_and_batch_macros.svh"

    logic [31:0] tex_mem [MaxSprites];
    logic [31:0] dep_mem [MaxSprites];
    logic [IdxW-1:0] ord_mem [MaxSprites];

    t_state r_state, n_state;
    logic [1:0] r_mode;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic r_ovf, n_ovf;
    logic [CntW-1:0] r_i, n_i, r_j, n_j, r_st, n_st, r_re, n_re;
    logic [IdxW-1:0] r_cur, n_cur, r_prev, n_prev;
    logic [31:0] r_ta, r_da, r_tb, r_db;
    logic r_ov, n_ov;
    logic [55:0] r_od, n_od;
    logic r_ol, n_ol;
    // one read address per cycle into the order store
    logic [IdxW-1:0] ord_ra, ord_q;
    logic ord_we;
    logic [IdxW-1:0] ord_wa, ord_wd;
    // record read addresses
    logic [IdxW-1:0] rec_a, rec_b;
    logic ld_a, ld_b;
    t_cmp cmp;
    logic in_acc;

    ssb_compare u_cmp (
        .i_mode (r_mode), .i_tex_a(r_ta), .i_dep_a(r_da),
        .i_tex_b(r_tb), .i_dep_b(r_db), .o_cmp(cmp)
    );

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;
    assign m_axis_tlast = r_ol;

    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tdata[0] && (r_cnt < CntW'(MaxSprites))) begin
            tex_mem[r_cnt[IdxW-1:0]] <= s_axis_tdata[32:1];
            dep_mem[r_cnt[IdxW-1:0]] <= s_axis_tdata[64:33];
        end
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        ord_q <= ord_mem[ord_ra];
        if (ld_a) begin
            r_ta <= tex_mem[rec_a];
            r_da <= dep_mem[rec_a];
        end
        if (ld_b) begin
            r_tb <= tex_mem[rec_b];
            r_db <= dep_mem[rec_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_mode  <= MODE_TEXTURE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
            r_ov  <= n_ov;
        end
        r_i <= n_i; r_j <= n_j; r_st <= n_st; r_re <= n_re;
        r_cur <= n_cur; r_prev <= n_prev; r_od <= n_od; r_ol <= n_ol;
    end

    logic [7:0] off6, len6;
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_ovf = r_ovf;
        n_i = r_i; n_j = r_j; n_st = r_st; n_re = r_re;
        n_cur = r_cur; n_prev = r_prev; n_ov = r_ov; n_od = r_od; n_ol = r_ol;
        ord_ra = '0; ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
        rec_a = ord_q; rec_b = ord_q; ld_a = 1'b0; ld_b = 1'b0;
        off6 = 8'(r_st) * 8'(VertsPerSprite);
        len6 = 8'(r_re - r_st) * 8'(VertsPerSprite);
        if (m_axis_tvalid && m_axis_tready) n_ov = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (s_axis_tdata[0]) begin
                        if (r_cnt < CntW'(MaxSprites)) begin
                            // order slot filled as the record lands
                            ord_we = 1'b1;
                            ord_wa = r_cnt[IdxW-1:0];
                            ord_wd = r_cnt[IdxW-1:0];
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (s_axis_tlast) begin
                        n_i = CntW'(1);
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // start pass i: cur = ord[i]; after the last pass, start batching
                if (r_i >= r_cnt) begin
                    n_st = '0;
                    n_state = ST_RUN_RD;
                    ord_ra = '0;
                end else begin
                    ord_ra = r_i[IdxW-1:0];
                    n_j = r_i;
                    n_state = ST_SORT_RD;
                end
            end
            ST_SORT_RD: begin
                // ord_q is cur; load its record and fetch the entry below
                n_cur = ord_q;
                rec_a = ord_q; ld_a = 1'b1;
                ord_ra = IdxW'(r_j - 1'b1);
                n_state = ST_SORT_DONE;
            end
            ST_SORT_DONE: begin
                n_prev = ord_q;
                rec_b = ord_q; ld_b = 1'b1;
                n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                if (r_j != '0 && cmp.ahead) begin
                    ord_we = 1'b1; ord_wa = r_j[IdxW-1:0]; ord_wd = r_prev;
                    n_j = r_j - 1'b1;
                    if (r_j == CntW'(1)) begin
                        // bottom reached: place cur in slot 0 next cycle
                        n_state = ST_SORT_CMP;
                    end else begin
                        ord_ra = IdxW'(r_j - 2'd2);
                        n_state = ST_SORT_DONE;
                    end
                end else begin
                    ord_we = 1'b1; ord_wa = r_j[IdxW-1:0]; ord_wd = r_cur;
                    n_i = r_i + 1'b1;
                    n_state = ST_INIT;
                end
            end
            ST_RUN_RD: begin
                // ord_q = ord[st]; load head texture, or finish the frame when st reaches the count
                if (r_st >= r_cnt) begin
                    n_cnt = '0; n_ovf = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    rec_a = ord_q; ld_a = 1'b1;
                    n_re = r_st + 1'b1;
                    ord_ra = IdxW'(r_st + 1'b1);
                    n_state = ST_RUN_LD;
                end
            end
            ST_RUN_LD: begin
                // ord_q = ord[re]; close the run at the frame end, else load the next record
                if (r_re >= r_cnt) begin
                    n_i = r_st;
                    ord_ra = r_st[IdxW-1:0];
                    n_state = ST_EMIT_RD;
                end else begin
                    rec_b = ord_q; ld_b = 1'b1;
                    n_state = ST_RUN_CMP;
                end
            end
            ST_RUN_CMP: begin
                if (cmp.same_tex) begin
                    n_re = r_re + 1'b1;
                    ord_ra = IdxW'(r_re + 1'b1);
                    n_state = ST_RUN_LD;
                end else begin
                    n_i = r_st;
                    ord_ra = r_st[IdxW-1:0];
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                rec_a = ord_q; ld_a = 1'b1;
                n_cur = ord_q;
                n_state = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_od = {1'b0, r_ovf, len6, off6, (r_i == r_st), r_ta, r_cur};
                    n_ol = (r_i + 1'b1 == r_cnt);
                    n_state = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT: begin
                if (r_i + 1'b1 >= r_re) begin
                    n_st = r_re;
                    ord_ra = r_re[IdxW-1:0];
                    n_state = ST_RUN_RD;
                end else begin
                    n_i = r_i + 1'b1;
                    ord_ra = IdxW'(r_i + 1'b1);
                    n_state = ST_EMIT_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    `SSB_ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, r_state != ST_LOAD, !s_axis_tready,
        "input taken while busy")
    `SSB_ASSERT_IMPL(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(MaxSprites),
        "sprite count past capacity")
    `SSB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule
`default_nettype wire

// ----- hdl/ssb_compare.sv -----
// Shared compare unit: ordering and texture equality of two records.
`timescale 1ns / 1ps
`default_nettype none
module ssb_compare (
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_tex_a,
    input  wire logic [31:0] i_dep_a,
    input  wire logic [31:0] i_tex_b,
    input  wire logic [31:0] i_dep_b,
    output ssb_pkg::t_cmp    o_cmp
);
    import ssb_pkg::*;
    logic signed [31:0] da, db;
    assign da = i_dep_a;
    assign db = i_dep_b;
    always_comb begin
        o_cmp.same_tex = (i_tex_a == i_tex_b);
        case (t_mode'(i_mode))
            MODE_TEXTURE:  o_cmp.ahead = i_tex_a < i_tex_b;
            MODE_DEPTH_UP: o_cmp.ahead = da < db;
            MODE_DEPTH_DN: o_cmp.ahead = da > db;
            default:       o_cmp.ahead = 1'b0;
        endcase
    end
endmodule
`default_nettype wire
